[sv/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
`default_nettype none
package swm_pkg;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int WINDOW_SIZE_WIDTH = 7;
   localparam logic [WINDOW_SIZE_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;
   localparam logic CSR_IDX_WINDOW_SIZE = 1'b0;

   // request handed from the front queue to the deque engine
   typedef struct packed {
      logic valid;
      logic start;
   } swm_item_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FRONT,
      BK_BACK_RD,
      BK_BACK_CMP,
      BK_WRITE,
      BK_HEAD_RD,
      BK_OUT
   } swm_back_state_type;

endpackage
`default_nettype wire

[sv/swm_req_if.sv]
// Request channel: one signed sample and a sequence start flag.
`default_nettype none
interface swm_req_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;
   logic                           sequence_start;

   modport source (output valid, sample_value, sequence_start, input ready);
   modport sink   (input valid, sample_value, sequence_start, output ready);
endinterface
`default_nettype wire

[sv/swm_rsp_if.sv]
// Response channel: window maximum.
`default_nettype none
interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, window_max, input ready);
   modport sink   (input valid, window_max, output ready);
endinterface
`default_nettype wire

[sv/swm_front.sv]
// Request intake: accepts samples into a short queue ahead of the deque engine.
`default_nettype none
module swm_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   swm_req_if.sink                             req_bus,
   output      swm_pkg::swm_item_ctl_type      item_ctl,
   output      logic signed [SAMPLE_WIDTH-1:0] item_sample,
   input  wire logic                           item_ready
);
   import swm_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic signed [SAMPLE_WIDTH-1:0] sample_q_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]         start_q_ff;
   logic [QAW-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]                 fill_ff, fill_in;
   logic                           push, pop;

   assign req_bus.ready = (fill_ff < QCW'(QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready;

   assign item_ctl    = '{valid: (fill_ff != '0), start: start_q_ff[rd_ptr_ff]};
   assign item_sample = sample_q_ff[rd_ptr_ff];
   assign pop         = item_ctl.valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         sample_q_ff[wr_ptr_ff] <= req_bus.sample_value;
         start_q_ff[wr_ptr_ff]  <= req_bus.sequence_start;
      end
   end

endmodule
`default_nettype wire

[sv/swm_back.sv]
// Deque engine: monotone candidate deque in a RAM, one compare per pop, output register.
`default_nettype none
module swm_back #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire swm_pkg::swm_item_ctl_type                 item_ctl,
   input  wire logic signed [SAMPLE_WIDTH-1:0]            item_sample,
   output      logic                                      item_ready,
   input  wire logic [swm_pkg::WINDOW_SIZE_WIDTH-1:0]     window_size,
   input  wire logic                                      window_clear,
   swm_rsp_if.source                                      rsp_bus
);
   import swm_pkg::*;

   localparam int IW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int PW = $clog2(2 * WINDOW_MAX);
   localparam int POS_LAST = 2 * WINDOW_MAX - 1;
   localparam int ENTRY_W = SAMPLE_WIDTH + PW;

   swm_back_state_type state_ff, state_in;

   logic [ENTRY_W-1:0]             mem [WINDOW_MAX];
   logic [ENTRY_W-1:0]             rd_data_ff;
   logic [IW-1:0]                  rd_addr;
   logic [IW-1:0]                  wr_addr;
   logic                           wr_en;

   logic [IW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [CW-1:0]                  seen_ff, seen_in;
   logic signed [SAMPLE_WIDTH-1:0] key_ff, key_in;
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] out_data_ff, out_data_in;

   logic [CW-1:0]                  win;
   logic signed [SAMPLE_WIDTH-1:0] rd_value;
   logic [PW-1:0]                  rd_pos;
   logic [PW:0]                    age;
   logic [IW:0]                    back_sum, tail_sum, head_sum;
   logic [IW-1:0]                  back_idx, tail_idx, head_next;
   logic [CW-1:0]                  seen_next;
   logic                           take_item, front_expire, back_drop;
   logic                           need_result, out_load;

   // window size 0 acts as 1, oversize saturates
   always_comb begin
      if (window_size == '0) begin
         win = CW'(1);
      end else if (32'(window_size) > WINDOW_MAX) begin
         win = CW'(WINDOW_MAX);
      end else begin
         win = CW'(window_size);
      end
   end

   assign rd_value = $signed(rd_data_ff[ENTRY_W-1 -: SAMPLE_WIDTH]);
   assign rd_pos   = rd_data_ff[PW-1:0];

   // age of the front entry, positions wrap at twice the window bound
   always_comb begin
      if (pos_ff >= rd_pos) begin
         age = {1'b0, pos_ff} - {1'b0, rd_pos};
      end else begin
         age = {1'b0, pos_ff} + (PW+1)'(2 * WINDOW_MAX) - {1'b0, rd_pos};
      end
   end

   always_comb begin
      back_sum = {1'b0, head_ff} + (IW+1)'(count_ff) - (IW+1)'(1);
      tail_sum = {1'b0, head_ff} + (IW+1)'(count_ff);
      head_sum = {1'b0, head_ff} + (IW+1)'(1);
      back_idx  = (back_sum >= (IW+1)'(WINDOW_MAX)) ?
                  IW'(back_sum - (IW+1)'(WINDOW_MAX)) : IW'(back_sum);
      tail_idx  = (tail_sum >= (IW+1)'(WINDOW_MAX)) ?
                  IW'(tail_sum - (IW+1)'(WINDOW_MAX)) : IW'(tail_sum);
      head_next = (head_sum >= (IW+1)'(WINDOW_MAX)) ?
                  IW'(head_sum - (IW+1)'(WINDOW_MAX)) : IW'(head_sum);
      seen_next = (seen_ff < win) ? seen_ff + CW'(1) : seen_ff;
   end

   assign take_item    = (state_ff == BK_IDLE) && item_ctl.valid;
   assign front_expire = (count_ff != '0) && (age >= (PW+1)'(win));
   assign back_drop    = (rd_value < key_ff);
   assign need_result  = (seen_next >= win);
   assign out_load     = !out_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_ctl.valid) begin
               state_in = BK_FRONT;
            end
         end
         BK_FRONT: begin
            state_in = BK_BACK_RD;
         end
         BK_BACK_RD: begin
            state_in = (count_ff == '0) ? BK_WRITE : BK_BACK_CMP;
         end
         BK_BACK_CMP: begin
            state_in = back_drop ? BK_BACK_RD : BK_WRITE;
         end
         BK_WRITE: begin
            state_in = need_result ? BK_HEAD_RD : BK_IDLE;
         end
         BK_HEAD_RD: begin
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      item_ready = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = tail_idx;
      unique case (state_ff)
         BK_IDLE: begin
            item_ready = 1'b1;
         end
         BK_BACK_RD: begin
            rd_addr = back_idx;
         end
         BK_WRITE: begin
            wr_en = (count_ff < CW'(WINDOW_MAX));
         end
         BK_FRONT, BK_BACK_CMP, BK_HEAD_RD, BK_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      key_in       = key_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (take_item) begin
               key_in = item_sample;
            end
            if (window_clear || (take_item && item_ctl.start)) begin
               head_in  = '0;
               count_in = '0;
               pos_in   = '0;
               seen_in  = '0;
            end
         end
         BK_FRONT: begin
            if (front_expire) begin
               head_in  = head_next;
               count_in = count_ff - CW'(1);
            end
         end
         BK_BACK_CMP: begin
            if (back_drop) begin
               count_in = count_ff - CW'(1);
            end
         end
         BK_WRITE: begin
            if (wr_en) begin
               count_in = count_ff + CW'(1);
            end
            pos_in  = (pos_ff == PW'(POS_LAST)) ? '0 : pos_ff + PW'(1);
            seen_in = seen_next;
         end
         BK_OUT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_data_in  = rd_value;
            end
         end
         BK_BACK_RD, BK_HEAD_RD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {key_ff, pos_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.window_max = out_data_ff;

endmodule
`default_nettype wire

[sv/sliding_window_maximum.sv]
// Sliding window maximum filter: top level with register port, intake queue and deque engine.
// Each accepted sample moves from the intake queue through the engine states FRONT (expire the
//   front entry), BACK_RD and BACK_CMP per back entry compared (no BACK_CMP once the deque is
//   empty), WRITE, and HEAD_RD and OUT when a response is due, OUT waiting for the response port.
//   The engine takes no new sample until back in IDLE; the intake queue accepts until full.
// Synchronous active-high reset empties queue and deque and sets window_size to 1.
`default_nettype none
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   swm_req_if.sink                                   req_bus,
   swm_rsp_if.source                                 rsp_bus,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [swm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output      logic [swm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output      logic                                 pready
);
   import swm_pkg::*;

   logic [WINDOW_SIZE_WIDTH-1:0]   window_size_ff, window_size_in;
   logic                           csr_index;
   logic                           window_wr;
   swm_item_ctl_type               item_ctl;
   logic signed [SAMPLE_WIDTH-1:0] item_sample;
   logic                           item_ready;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1];
   assign window_wr = psel && penable && pwrite && (csr_index == CSR_IDX_WINDOW_SIZE);

   assign window_size_in = window_wr ? pwdata[WINDOW_SIZE_WIDTH-1:0] : window_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == CSR_IDX_WINDOW_SIZE) begin
         prdata = CSR_DATA_WIDTH'(window_size_ff);
      end
   end

   swm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .item_ctl    (item_ctl),
      .item_sample (item_sample),
      .item_ready  (item_ready)
   );

   swm_back #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item_ctl     (item_ctl),
      .item_sample  (item_sample),
      .item_ready   (item_ready),
      .window_size  (window_size_ff),
      .window_clear (window_wr),
      .rsp_bus      (rsp_bus)
   );

endmodule
`default_nettype wire

[sv/swm_checker.sv]
// Port-level checks for the sliding window maximum block, bound to the top level.
`default_nettype none
module swm_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [SAMPLE_WIDTH-1:0] rsp_data,
   input wire logic                    psel,
   input wire logic                    penable,
   input wire logic                    pwrite,
   input wire logic                    paddr_index,
   input wire logic [6:0]              pwdata_low,
   input wire logic [6:0]              prdata_low,
   input wire logic                    pready
);
   // requests taken minus responses delivered
   logic [31:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 32'(req_valid && req_ready)
                       - 32'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without an outstanding request");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && !paddr_index && !$past(reset)
      |=> prdata_low == $past(pwdata_low))
      else $error("window_size readback mismatch");

endmodule

bind sliding_window_maximum swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_data    (rsp_bus.window_max),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr_index (paddr[2]),
   .pwdata_low  (pwdata[6:0]),
   .prdata_low  (prdata[6:0]),
   .pready      (pready)
);
`default_nettype wire
